@@ rtl/core/gcrdec_pkg.sv @@
// Shared types, constants and the 6-and-2 GCR code lookup for the sector decoder.
// No dependencies; every other file of the decoder but gcrdec_ram imports this package.
package gcrdec_pkg;

    // Default geometry of a data record.
    localparam int FRAGMENT_ENTRIES_DEF = 86;
    localparam int SECTOR_BYTES_DEF     = 256;

    // Fixed field widths.
    localparam int CODE_W  = 8;
    localparam int VALUE_W = 6;
    localparam int INDEX_W = 8;
    localparam int GROUP_W = 2;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Value substituted for a nibble that is not a valid code.
    localparam logic [VALUE_W-1:0] BAD_VALUE = 6'h3F;

    // Fragment group selectors.
    localparam logic [GROUP_W-1:0] GROUP_LOW  = 2'd0;
    localparam logic [GROUP_W-1:0] GROUP_MID  = 2'd1;
    localparam logic [GROUP_W-1:0] GROUP_HIGH = 2'd2;

    // The 64 valid disk codes, indexed by their 6-bit value.
    localparam logic [CODE_W-1:0] GCR_CODES [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } gcr_result_t;

    // Work that the front part hands to the back part for one result item.
    typedef struct packed {
        logic               is_status;
        logic               checksum_ok;
        logic               bad_code_seen;
        logic [VALUE_W-1:0] chain;
        logic [INDEX_W-1:0] byte_index;
        logic [GROUP_W-1:0] group;
    } gcrdec_desc_t;

    // Queue entry: the descriptor plus the fragment word read for it.
    typedef struct packed {
        gcrdec_desc_t       desc;
        logic [VALUE_W-1:0] frag;
    } gcrdec_entry_t;

    // Maps a disk code to its 6-bit value; invalid codes give BAD_VALUE.
    function automatic gcr_result_t gcr_decode(input logic [CODE_W-1:0] code);
        gcr_result_t res;
        res.valid = 1'b0;
        res.value = '0;
        for (int k = 0; k < 64; k++) begin
            if (GCR_CODES[k] == code) begin
                res.valid = 1'b1;
                res.value = res.value | VALUE_W'(k);
            end
        end
        if (!res.valid) begin
            res.value = BAD_VALUE;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/gcrdec_ifs.sv @@
// Valid/ready channel interfaces for the sector decoder: nibbles in, results out.
// Depends on gcrdec_pkg for field widths.
interface gcrdec_nibble_if import gcrdec_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] disk_byte;
    logic              record_start;

    modport source (output valid, output disk_byte, output record_start, input ready);
    modport sink   (input valid, input disk_byte, input record_start, output ready);
endinterface

interface gcrdec_result_if import gcrdec_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               is_status;
    logic               checksum_ok;
    logic               bad_code_seen;
    logic               last;

    modport source (output valid, output data_byte, output byte_index, output is_status,
                    output checksum_ok, output bad_code_seen, output last, input ready);
    modport sink   (input valid, input data_byte, input byte_index, input is_status,
                    input checksum_ok, input bad_code_seen, input last, output ready);
endinterface

@@ rtl/core/gcrdec_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gcrdec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/gcrdec_front.sv @@
// Front part of the decoder: accepts nibbles, decodes codes, runs the chain and
// position, writes and reads the fragment store. Depends on gcrdec_pkg, gcrdec_ifs.
module gcrdec_front import gcrdec_pkg::*; #(
    parameter int FRAGMENT_ENTRIES = FRAGMENT_ENTRIES_DEF,
    parameter int SECTOR_BYTES     = SECTOR_BYTES_DEF,
    localparam int ADDR_W = $clog2(FRAGMENT_ENTRIES),
    localparam int POS_W  = $clog2(FRAGMENT_ENTRIES + SECTOR_BYTES + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gcrdec_nibble_if.sink        nibble,
    input  logic [QCOUNT_W-1:0]  q_count,
    output logic                 push,
    output gcrdec_entry_t        push_entry,
    output logic                 ram_we,
    output logic [ADDR_W-1:0]    ram_waddr,
    output logic [VALUE_W-1:0]   ram_wdata,
    output logic                 ram_re,
    output logic [ADDR_W-1:0]    ram_raddr,
    input  logic [VALUE_W-1:0]   ram_rdata
);

    localparam logic [POS_W-1:0]   FRAG_POS  = POS_W'(FRAGMENT_ENTRIES);
    localparam logic [POS_W-1:0]   CHECK_POS = POS_W'(FRAGMENT_ENTRIES + SECTOR_BYTES);
    localparam logic [POS_W-1:0]   IDLE_POS  = POS_W'(FRAGMENT_ENTRIES + SECTOR_BYTES + 1);
    localparam logic [INDEX_W-1:0] FRAG_I    = INDEX_W'(FRAGMENT_ENTRIES);
    localparam logic [INDEX_W-1:0] FRAG2_I   = INDEX_W'(2 * FRAGMENT_ENTRIES);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] chain_reg, chain_next;
    logic               bad_reg, bad_next;
    logic               stage_v_reg;
    gcrdec_desc_t       stage_desc_reg;

    logic               accept;
    logic [POS_W-1:0]   pos_eff;
    logic [VALUE_W-1:0] chain_eff, chain_upd;
    logic               bad_eff, bad_upd;
    gcr_result_t        dec;
    logic               at_check, in_frag, active, emit;
    logic [INDEX_W-1:0] j;
    logic [GROUP_W-1:0] group;
    logic [ADDR_W-1:0]  k;
    gcrdec_desc_t       desc;
    logic [QCOUNT_W:0]  pending;

    // Space in the queue is counted including the item held in the stage register.
    assign pending      = {1'b0, q_count} + (QCOUNT_W + 1)'(stage_v_reg);
    assign nibble.ready = pending < (QCOUNT_W + 1)'(QUEUE_DEPTH);
    assign accept       = nibble.valid && nibble.ready;

    // Decode the nibble and work out where it falls in the record.
    always_comb
    begin
        pos_eff   = nibble.record_start ? '0 : pos_reg;
        chain_eff = nibble.record_start ? '0 : chain_reg;
        bad_eff   = nibble.record_start ? 1'b0 : bad_reg;
        dec       = gcr_decode(nibble.disk_byte);
        bad_upd   = bad_eff | ~dec.valid;
        chain_upd = chain_eff ^ dec.value;
        active    = pos_eff < IDLE_POS;
        at_check  = pos_eff == CHECK_POS;
        in_frag   = pos_eff < FRAG_POS;
        j         = INDEX_W'(pos_eff - FRAG_POS);

        // Data byte j takes its low bits from fragment word j mod 86, group j / 86.
        if (j < FRAG_I)
        begin
            group = GROUP_LOW;
            k     = ADDR_W'(j);
        end
        else if (j < FRAG2_I)
        begin
            group = GROUP_MID;
            k     = ADDR_W'(j - FRAG_I);
        end
        else
        begin
            group = GROUP_HIGH;
            k     = ADDR_W'(j - FRAG2_I);
        end

        desc.is_status     = at_check;
        desc.checksum_ok   = at_check && dec.valid && (dec.value == chain_eff);
        desc.bad_code_seen = bad_upd;
        desc.chain         = chain_upd;
        desc.byte_index    = at_check ? '0 : j;
        desc.group         = group;
    end

    // State update for an accepted nibble.
    always_comb
    begin
        pos_next   = pos_reg;
        chain_next = chain_reg;
        bad_next   = bad_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        emit       = 1'b0;
        if (accept)
        begin
            pos_next   = pos_eff;
            chain_next = chain_eff;
            bad_next   = bad_eff;
            if (active)
            begin
                bad_next = bad_upd;
                if (at_check)
                begin
                    pos_next = IDLE_POS;
                    emit     = 1'b1;
                end
                else
                begin
                    chain_next = chain_upd;
                    pos_next   = pos_eff + POS_W'(1);
                    if (in_frag)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                        emit   = 1'b1;
                    end
                end
            end
        end
    end

    assign ram_waddr = ADDR_W'(pos_eff);
    assign ram_wdata = chain_upd;
    assign ram_raddr = k;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= IDLE_POS;
            chain_reg   <= '0;
            bad_reg     <= 1'b0;
            stage_v_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            chain_reg   <= chain_next;
            bad_reg     <= bad_next;
            stage_v_reg <= emit;
        end
    end

    // The descriptor is held in the stage register while the fragment word comes out of the RAM.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            stage_desc_reg <= desc;
        end
    end

    assign push            = stage_v_reg;
    assign push_entry.desc = stage_desc_reg;
    assign push_entry.frag = ram_rdata;

    // The position never goes past the idle value.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= IDLE_POS)
        else $error("position beyond idle value");

    // An item in the stage register always finds room in the queue.
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        stage_v_reg |-> (q_count < QCOUNT_W'(QUEUE_DEPTH)))
        else $error("stage item has no queue room");

endmodule

@@ rtl/core/gcrdec_queue.sv @@
// Short queue between the front and back parts of the decoder.
// Depends on gcrdec_pkg.
module gcrdec_queue import gcrdec_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gcrdec_entry_t       push_entry,
    input  logic                pop,
    output gcrdec_entry_t       head,
    output logic                not_empty,
    output logic [QCOUNT_W-1:0] count
);

    gcrdec_entry_t       slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCOUNT_W'(push) - QCOUNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head      = slots[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCOUNT_W'(QUEUE_DEPTH) || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

endmodule

@@ rtl/core/gcrdec_back.sv @@
// Back part of the decoder: assembles data bytes from the chain and fragment bits
// and holds the result item in the output register. Depends on gcrdec_pkg, gcrdec_ifs.
module gcrdec_back import gcrdec_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  gcrdec_entry_t   head,
    input  logic            not_empty,
    output logic            pop,
    gcrdec_result_if.source result
);

    logic               out_valid_reg;
    logic [CODE_W-1:0]  data_byte_reg;
    logic [INDEX_W-1:0] byte_index_reg;
    logic               is_status_reg;
    logic               checksum_ok_reg;
    logic               bad_code_seen_reg;

    logic [1:0]         pair;
    logic [CODE_W-1:0]  byte_val;

    // Take the next entry whenever the output register is empty or being emptied.
    assign pop = not_empty && (!out_valid_reg || result.ready);

    // Pick the fragment pair of the entry's group and swap its two bits.
    always_comb
    begin
        unique case (head.desc.group)
            GROUP_LOW:  pair = head.frag[1:0];
            GROUP_MID:  pair = head.frag[3:2];
            GROUP_HIGH: pair = head.frag[5:4];
            default:    pair = 2'b00;
        endcase
        byte_val = head.desc.is_status ? '0 : {head.desc.chain, pair[0], pair[1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_byte_reg     <= byte_val;
            byte_index_reg    <= head.desc.byte_index;
            is_status_reg     <= head.desc.is_status;
            checksum_ok_reg   <= head.desc.checksum_ok;
            bad_code_seen_reg <= head.desc.bad_code_seen;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.data_byte     = data_byte_reg;
    assign result.byte_index    = byte_index_reg;
    assign result.is_status     = is_status_reg;
    assign result.checksum_ok   = checksum_ok_reg;
    assign result.bad_code_seen = bad_code_seen_reg;
    assign result.last          = is_status_reg;

endmodule

@@ rtl/core/gcr_six_and_two_sector_decode.sv @@
// Top level of the 6-and-2 GCR data record decoder.
// A result item passes through the stage register, the queue and the output register.
// Throughput: one nibble per cycle while the queue has room; the code lookup and chain XOR are combinational.
// The 4-entry queue between front and back lets either side stall on its own.
// Reset clears the chain, the bad-code flag and the queue and leaves the decoder idle;
// the fragment RAM is not cleared, as each record writes it before reading it.
module gcr_six_and_two_sector_decode import gcrdec_pkg::*; #(
    parameter int FRAGMENT_ENTRIES = FRAGMENT_ENTRIES_DEF,
    parameter int SECTOR_BYTES     = SECTOR_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    gcrdec_nibble_if.sink   nibble,
    gcrdec_result_if.source result
);

    localparam int ADDR_W = $clog2(FRAGMENT_ENTRIES);

    logic                push;
    gcrdec_entry_t       push_entry;
    logic                pop;
    gcrdec_entry_t       head;
    logic                not_empty;
    logic [QCOUNT_W-1:0] q_count;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    // Front part: nibble intake, chain and fragment store access.
    gcrdec_front #(
        .FRAGMENT_ENTRIES (FRAGMENT_ENTRIES),
        .SECTOR_BYTES     (SECTOR_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .nibble     (nibble),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Fragment store.
    gcrdec_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (FRAGMENT_ENTRIES)
    ) u_frag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Queue between front and back.
    gcrdec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .count      (q_count)
    );

    // Back part: byte assembly and output register.
    gcrdec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
